### src/ffpa_pkg.sv
package ffpa_pkg;

  localparam int unsigned POOL_MAX_BYTES = 4096;
  localparam int unsigned HEADER_BYTES   = 8;
  localparam int unsigned RESET_POOL     = 4096;

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned OFF_W   = 15;
  localparam int unsigned SZ_W    = 14;
  localparam int unsigned ENTRY_W = SZ_W + 1;
  localparam int unsigned SIZE_CAP = 2 * POOL_MAX_BYTES;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

endpackage

### src/ffpa_ram.sv
module ffpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/first_fit_pool_allocator_unit.sv
// Channel   | Direction | Handshake                    | Payload
// request   | in        | start high, busy low         | opcode, has_address, block_address,
//           |           |                              | req_size
// result    | out       | done_o strobe, one cycle     | granted, data_address, moved,
//           |           |                              | old_address, copy_length
// config    | in        | cfg_valid_i and cfg_ready_o  | cfg_pool_bytes_i
//
// Steps: the first-fit walk reads and then checks every block header it visits
// (ST_WALK_RD, ST_WALK_CHK), reads and checks each neighbour it tries to merge
// (ST_MRG_RD, ST_MRG_CHK) and writes back each free block (ST_MRG_WB); a fit
// adds the split (ST_SPL_2ND, ST_SPL_BLK), and the result strobes in the cycle after.
// A free strobes after ST_FREE_RD and ST_FREE_WR, a null or rejected request in
// the cycle after acceptance. A reallocate loads its block (ST_REAL_RD, ST_REAL_LD),
// then its own merge and split; when it moves, a full allocate walk follows, then
// ST_OLD_RD and ST_OLD_WR release the old block. Reset and every pool_bytes write
// start a clearing pass over the header memory, during which busy stays high.
// The result strobe cannot be stalled: it is held for exactly one cycle.
module first_fit_pool_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic        has_address_i,
  input  logic [11:0] block_address_i,
  input  logic [12:0] req_size_i,
  output logic        done_o,
  output logic        granted_o,
  output logic [11:0] data_address_o,
  output logic        moved_o,
  output logic [11:0] old_address_o,
  output logic [11:0] copy_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_pool_bytes_i
);

  localparam int unsigned AW  = ffpa_pkg::ADDR_W;
  localparam int unsigned OW  = ffpa_pkg::OFF_W;
  localparam int unsigned SW  = ffpa_pkg::SZ_W;
  localparam int unsigned EW  = ffpa_pkg::ENTRY_W;
  localparam logic [OW-1:0] HDR = OW'(ffpa_pkg::HEADER_BYTES);
  localparam logic [OW-1:0] CAP = OW'(ffpa_pkg::SIZE_CAP);
  localparam logic [12:0] PMAX = 13'(ffpa_pkg::POOL_MAX_BYTES);
  localparam logic [AW-1:0] LAST = AW'(ffpa_pkg::POOL_MAX_BYTES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FREE_RD, ST_FREE_WR, ST_REAL_RD, ST_REAL_LD,
    ST_WALK_RD, ST_WALK_CHK, ST_MRG_RD, ST_MRG_CHK, ST_MRG_WB,
    ST_SPL_2ND, ST_SPL_BLK, ST_OLD_RD, ST_OLD_WR
  } state_e;

  typedef enum logic [2:0] {
    MD_ALLOC, MD_REALLOC, MD_GROW, MD_RESTORE, MD_TAKE
  } mode_e;

  state_e        state_q, state_d;
  mode_e         mode_q, mode_d;
  logic [12:0]   pool_q, pool_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [OW-1:0] b_q, b_d;
  logic [OW-1:0] n_q, n_d;
  logic [SW-1:0] bsz_q, bsz_d;
  logic          bused_q, bused_d;
  logic [SW-1:0] orig_q, orig_d;
  logic [SW-1:0] spl_q, spl_d;
  logic [12:0]   need_q, need_d;
  logic [AW-1:0] h_q, h_d;
  logic [AW-1:0] nd_q, nd_d;

  logic          done_q, done_d;
  logic          gr_q, gr_d;
  logic [11:0]   da_q, da_d;
  logic          mv_q, mv_d;
  logic [11:0]   oa_q, oa_d;
  logic [11:0]   cl_q, cl_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [SW-1:0] rsz;
  logic          rused;
  logic [12:0]   plen;
  logic [SW-1:0] init_sz;
  logic          addr_ok;
  logic [OW-1:0] sum;
  logic [OW-1:0] second;
  logic          spl_ok;

  function automatic logic in_walk(input logic [OW-1:0] x, input logic [12:0] pl);
    in_walk = (x + HDR) < {2'b00, pl};
  endfunction

  assign rsz     = rdata[SW-1:0];
  assign rused   = rdata[EW-1];
  assign plen    = (pool_q > PMAX) ? PMAX : pool_q;
  assign init_sz = ({2'b00, plen} > HDR) ? SW'({2'b00, plen} - HDR) : '0;
  assign addr_ok = ({3'b000, block_address_i} >= HDR) && ({1'b0, block_address_i} < plen);
  assign sum     = {1'b0, bsz_q} + {1'b0, rsz} + HDR;
  assign second  = b_q + HDR + {1'b0, spl_q};
  assign spl_ok  = ({1'b0, spl_q} + HDR < {1'b0, bsz_q}) && in_walk(second, plen);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  ffpa_ram #(
    .WIDTH(EW),
    .DEPTH(ffpa_pkg::POOL_MAX_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    pool_d  = pool_q;
    clr_d   = clr_q;
    b_d     = b_q;
    n_d     = n_q;
    bsz_d   = bsz_q;
    bused_d = bused_q;
    orig_d  = orig_q;
    spl_d   = spl_q;
    need_d  = need_q;
    h_d     = h_q;
    nd_d    = nd_q;
    done_d  = 1'b0;
    gr_d    = gr_q;
    da_d    = da_q;
    mv_d    = mv_q;
    oa_d    = oa_q;
    cl_d    = cl_q;
    we      = 1'b0;
    waddr   = b_q[AW-1:0];
    wdata   = {bused_q, bsz_q};
    raddr   = b_q[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        // sweep the header store; entry 0 gets the one free block
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? {1'b0, init_sz} : '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          need_d = req_size_i;
          h_d    = block_address_i - AW'(ffpa_pkg::HEADER_BYTES);
          gr_d   = 1'b0;
          da_d   = '0;
          mv_d   = 1'b0;
          oa_d   = '0;
          cl_d   = '0;
          if (opcode_i == ffpa_pkg::OP_ALLOC ||
              (opcode_i == ffpa_pkg::OP_REALLOC && !has_address_i)) begin
            mode_d  = MD_ALLOC;
            b_d     = '0;
            state_d = ST_WALK_RD;
          end else if (opcode_i == ffpa_pkg::OP_FREE && has_address_i && addr_ok) begin
            state_d = ST_FREE_RD;
          end else if (opcode_i == ffpa_pkg::OP_REALLOC && addr_ok) begin
            state_d = ST_REAL_RD;
          end else begin
            // drop: nothing changes, answer all zero
            done_d = 1'b1;
          end
        end
      end
      ST_FREE_RD: begin
        raddr   = h_q;
        state_d = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        we      = 1'b1;
        waddr   = h_q;
        wdata   = {1'b0, rsz};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_REAL_RD: begin
        raddr   = h_q;
        state_d = ST_REAL_LD;
      end
      ST_REAL_LD: begin
        b_d     = {3'b000, h_q};
        bsz_d   = rsz;
        orig_d  = rsz;
        bused_d = 1'b1;
        n_d     = {3'b000, h_q} + HDR + {1'b0, rsz};
        mode_d  = MD_REALLOC;
        state_d = ST_MRG_RD;
      end
      ST_WALK_RD: begin
        raddr = b_q[AW-1:0];
        if (in_walk(b_q, plen)) begin
          state_d = ST_WALK_CHK;
        end else begin
          // no fit: the old block, if any, stays where it is
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_WALK_CHK: begin
        if (rused) begin
          b_d     = b_q + HDR + {1'b0, rsz};
          state_d = ST_WALK_RD;
        end else begin
          bsz_d   = rsz;
          bused_d = 1'b0;
          n_d     = b_q + HDR + {1'b0, rsz};
          state_d = ST_MRG_RD;
        end
      end
      ST_MRG_RD: begin
        raddr = n_q[AW-1:0];
        if (in_walk(n_q, plen)) begin
          state_d = ST_MRG_CHK;
        end else begin
          state_d = ST_MRG_WB;
        end
      end
      ST_MRG_CHK: begin
        if (rused) begin
          state_d = ST_MRG_WB;
        end else begin
          // absorb the free successor, saturating the size
          bsz_d   = (sum > CAP) ? CAP[SW-1:0] : sum[SW-1:0];
          n_d     = b_q + HDR + ((sum > CAP) ? CAP : sum);
          state_d = ST_MRG_RD;
        end
      end
      ST_MRG_WB: begin
        we    = 1'b1;
        waddr = b_q[AW-1:0];
        wdata = {bused_q, bsz_q};
        if (mode_q == MD_REALLOC) begin
          if (bsz_q >= {1'b0, need_q}) begin
            mode_d = MD_GROW;
            spl_d  = {1'b0, need_q};
          end else begin
            mode_d = MD_RESTORE;
            spl_d  = orig_q;
          end
          state_d = ST_SPL_2ND;
        end else if (bsz_q >= {1'b0, need_q}) begin
          spl_d   = {1'b0, need_q};
          state_d = ST_SPL_2ND;
        end else begin
          b_d     = b_q + HDR + {1'b0, bsz_q};
          state_d = ST_WALK_RD;
        end
      end
      ST_SPL_2ND: begin
        // carve off the tail when more than a header is left
        if (spl_ok) begin
          we    = 1'b1;
          waddr = second[AW-1:0];
          wdata = {1'b0, bsz_q - spl_q - SW'(ffpa_pkg::HEADER_BYTES)};
          bsz_d = spl_q;
        end
        state_d = ST_SPL_BLK;
      end
      ST_SPL_BLK: begin
        we      = 1'b1;
        waddr   = b_q[AW-1:0];
        wdata   = {1'b1, bsz_q};
        bused_d = 1'b1;
        case (mode_q)
          MD_ALLOC: begin
            gr_d    = 1'b1;
            da_d    = AW'(b_q + HDR);
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          MD_GROW: begin
            gr_d    = 1'b1;
            da_d    = h_q + AW'(ffpa_pkg::HEADER_BYTES);
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          MD_RESTORE: begin
            mode_d  = MD_TAKE;
            b_d     = '0;
            state_d = ST_WALK_RD;
          end
          MD_TAKE: begin
            nd_d    = AW'(b_q + HDR);
            state_d = ST_OLD_RD;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_OLD_RD: begin
        raddr   = h_q;
        state_d = ST_OLD_WR;
      end
      ST_OLD_WR: begin
        // release the old block; its current size is the copy length
        we      = 1'b1;
        waddr   = h_q;
        wdata   = {1'b0, rsz};
        gr_d    = 1'b1;
        da_d    = nd_q;
        mv_d    = 1'b1;
        oa_d    = h_q + AW'(ffpa_pkg::HEADER_BYTES);
        cl_d    = rsz[11:0];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      // a new pool size empties the pool: restart the clearing pass
      pool_d  = cfg_pool_bytes_i;
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q  <= MD_ALLOC;
      pool_q  <= 13'(ffpa_pkg::RESET_POOL);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pool_q  <= pool_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q     <= b_d;
    n_q     <= n_d;
    bsz_q   <= bsz_d;
    bused_q <= bused_d;
    orig_q  <= orig_d;
    spl_q   <= spl_d;
    need_q  <= need_d;
    h_q     <= h_d;
    nd_q    <= nd_d;
    gr_q    <= gr_d;
    da_q    <= da_d;
    mv_q    <= mv_d;
    oa_q    <= oa_d;
    cl_q    <= cl_d;
  end

  assign done_o         = done_q;
  assign granted_o      = gr_q;
  assign data_address_o = da_q;
  assign moved_o        = mv_q;
  assign old_address_o  = oa_q;
  assign copy_length_o  = cl_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [1:0]  OP_UNKNOWN  = 2'd3;
  localparam int unsigned PMAX        = ffpa_pkg::POOL_MAX_BYTES;
  localparam int unsigned HDR         = ffpa_pkg::HEADER_BYTES;

  // One result of the allocator, as the ports carry it.
  typedef struct packed {
    logic        granted;
    logic [11:0] data_address;
    logic        moved;
    logic [11:0] old_address;
    logic [11:0] copy_length;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = ffpa_pkg::OP_ALLOC;
  logic        has_address_i = 1'b0;
  logic [11:0] block_address_i = '0;
  logic [12:0] req_size_i = '0;
  logic        done_o;
  logic        granted_o;
  logic [11:0] data_address_o;
  logic        moved_o;
  logic [11:0] old_address_o;
  logic [11:0] copy_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [12:0] cfg_pool_bytes_i = '0;

  first_fit_pool_allocator_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .has_address_i    (has_address_i),
    .block_address_i  (block_address_i),
    .req_size_i       (req_size_i),
    .done_o           (done_o),
    .granted_o        (granted_o),
    .data_address_o   (data_address_o),
    .moved_o          (moved_o),
    .old_address_o    (old_address_o),
    .copy_length_o    (copy_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_pool_bytes_i (cfg_pool_bytes_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted pool: one header (size, used mark) per byte offset.
  int unsigned   pool_reg;
  int unsigned   hdr_size [0:PMAX-1];
  bit            hdr_used [0:PMAX-1];

  alloc_result_t pending_results [$];
  logic [11:0]   live_blocks [$];   // data offsets believed to be allocated

  int unsigned   cycle_count;
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   n_alloc, n_free, n_realloc, n_moved, n_refused, n_cfg;
  bit            no_idle;

  // ---------------------------------------------------------------------------
  // Pool predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned pool_len();
    return (pool_reg > PMAX) ? PMAX : pool_reg;
  endfunction

  function automatic bit in_chain(int unsigned b);
    return (b + HDR) < pool_len();
  endfunction

  function automatic int unsigned next_block(int unsigned b);
    return b + HDR + hdr_size[b];
  endfunction

  function automatic void empty_pool();
    int unsigned p;
    p = pool_len();
    for (int i = 0; i < PMAX; i++) begin
      hdr_size[i] = 0;
      hdr_used[i] = 1'b0;
    end
    hdr_size[0] = (p > HDR) ? p - HDR : 0;
  endfunction

  // Absorb every free block that directly follows block b.
  function automatic void coalesce(int unsigned b);
    int unsigned n;
    int unsigned s;
    n = next_block(b);
    while (in_chain(n) && !hdr_used[n]) begin
      s = hdr_size[b] + hdr_size[n] + HDR;
      hdr_size[b] = (s > ffpa_pkg::SIZE_CAP) ? ffpa_pkg::SIZE_CAP : s;
      n = next_block(b);
    end
  endfunction

  // First-fit walk from offset 0; returns -1 when nothing fits.
  function automatic int first_fit(int unsigned need);
    int unsigned b;
    b = 0;
    while (in_chain(b)) begin
      if (!hdr_used[b]) begin
        coalesce(b);
        if (hdr_size[b] >= need) return int'(b);
      end
      b = next_block(b);
    end
    return -1;
  endfunction

  // Trim block b to size when more than a header would be left; marks it free.
  function automatic void trim_block(int unsigned b, int unsigned size);
    int unsigned orig;
    int unsigned second;
    orig = hdr_size[b];
    second = b + HDR + size;
    hdr_used[b] = 1'b0;
    if ((size + HDR < orig) && (second + HDR < pool_len())) begin
      hdr_size[b] = size;
      hdr_size[second] = orig - size - HDR;
      hdr_used[second] = 1'b0;
    end
  endfunction

  function automatic int claim_block(int unsigned need);
    int b;
    b = first_fit(need);
    if (b < 0) return -1;
    trim_block(b, need);
    hdr_used[b] = 1'b1;
    return b;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] op, logic has,
                                                    logic [11:0] addr, logic [12:0] size);
    alloc_result_t r;
    bit            addr_ok;
    int            b;
    int unsigned   h;
    int unsigned   orig;
    r = '0;
    addr_ok = (addr >= HDR) && (addr < pool_len());
    if (op == ffpa_pkg::OP_ALLOC || (op == ffpa_pkg::OP_REALLOC && !has)) begin
      b = claim_block(size);
      if (b >= 0) begin
        r.granted = 1'b1;
        r.data_address = 12'(b + HDR);
      end
    end else if (op == ffpa_pkg::OP_FREE) begin
      if (has && addr_ok) hdr_used[addr - HDR] = 1'b0;
    end else if (op == ffpa_pkg::OP_REALLOC && addr_ok) begin
      h = addr - HDR;
      orig = hdr_size[h];
      hdr_used[h] = 1'b0;
      coalesce(h);
      hdr_used[h] = 1'b1;
      if (hdr_size[h] >= size) begin
        // grown (or shrunk) in place
        trim_block(h, size);
        hdr_used[h] = 1'b1;
        r.granted = 1'b1;
        r.data_address = addr;
      end else begin
        // give back what was merged, then look elsewhere
        trim_block(h, orig);
        hdr_used[h] = 1'b1;
        b = claim_block(size);
        if (b >= 0) begin
          r.granted = 1'b1;
          r.data_address = 12'(b + HDR);
          r.moved = 1'b1;
          r.old_address = addr;
          r.copy_length = 12'(hdr_size[h]);
          hdr_used[h] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: done_o cannot be stalled, so take each strobe as it comes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    got = {granted_o, data_address_o, moved_o, old_address_o, copy_length_o};
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result at cycle %0d: granted=%0d data=%0d",
                   cycle_count, got.granted, got.data_address);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR: result %0d mismatch: granted %0d/%0d data %0d/%0d ",
                      "moved %0d/%0d old %0d/%0d copy %0d/%0d (expected/actual)"},
                     results_seen, want.granted, got.granted, want.data_address,
                     got.data_address, want.moved, got.moved, want.old_address,
                     got.old_address, want.copy_length, got.copy_length);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Enter and leave at a falling edge. Hold start high after acceptance when
  // no gap is drawn, so that back-to-back requests never drop start.
  task automatic send_request(logic [1:0] op, logic has, logic [11:0] addr,
                              logic [12:0] size);
    alloc_result_t r;
    int unsigned   gap;
    start           <= 1'b1;
    opcode_i        <= op;
    has_address_i   <= has;
    block_address_i <= addr;
    req_size_i      <= size;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = predict_request(op, has, addr, size);
    pending_results.push_back(r);
    case (op)
      ffpa_pkg::OP_ALLOC:   n_alloc++;
      ffpa_pkg::OP_FREE:    n_free++;
      ffpa_pkg::OP_REALLOC: n_realloc++;
      default:    ;
    endcase
    if (r.moved) n_moved++;
    if ((op == ffpa_pkg::OP_ALLOC || op == ffpa_pkg::OP_REALLOC) && !r.granted) n_refused++;
    // keep the list of live blocks in step with the prediction
    if (op == ffpa_pkg::OP_FREE && has) begin
      foreach (live_blocks[i]) if (live_blocks[i] == addr) begin
        live_blocks.delete(i);
        break;
      end
    end
    if (r.moved) begin
      foreach (live_blocks[i]) if (live_blocks[i] == r.old_address) begin
        live_blocks.delete(i);
        break;
      end
    end
    if (r.granted && (op == ffpa_pkg::OP_ALLOC || !has || r.moved))
      live_blocks.push_back(r.data_address);
    @(negedge clk_i);
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic lower_start();
    start <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold off until every outstanding result has arrived.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Write pool_bytes; the block clears its pool, and so does the predictor.
  task automatic write_pool_bytes(logic [12:0] value);
    lower_start();
    drain_results();
    cfg_valid_i      <= 1'b1;
    cfg_pool_bytes_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    pool_reg = value;
    empty_pool();
    live_blocks.delete();
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Draw a request size, mostly small against the pool, rarely huge.
  function automatic logic [12:0] draw_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 13'($urandom_range(0, (pool_len() / 6) + 1));
    if (roll < 90) return 13'($urandom_range(0, pool_len()));
    return 13'($urandom_range(0, 4096));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_ops();
    logic [11:0] a, b;
    // exact fit of the whole pool, then refusal while it is held
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd4088);
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd0);
    send_request(ffpa_pkg::OP_FREE,  1'b1, 12'd8, 13'd0);
    // too large for the pool, and one of the full pool size
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd4089);
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd4096);
    // a zero-size block, then blocks of 16 and 32 bytes
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd0);
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd16);
    send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, 13'd32);
    // null free, null reallocate acting as allocate
    send_request(ffpa_pkg::OP_FREE,    1'b0, 12'd40, 13'd0);
    send_request(ffpa_pkg::OP_REALLOC, 1'b0, 12'd0,  13'd24);
    // out-of-range addresses for free and reallocate
    send_request(ffpa_pkg::OP_FREE,    1'b1, 12'd0,    13'd0);
    send_request(ffpa_pkg::OP_FREE,    1'b1, 12'd7,    13'd0);
    send_request(ffpa_pkg::OP_REALLOC, 1'b1, 12'd4,    13'd8);
    // a free at b, two reallocates of a, then a reallocate that cannot fit
    a = 12'd16;
    b = 12'd32;
    send_request(ffpa_pkg::OP_FREE,    1'b1, b, 13'd0);
    send_request(ffpa_pkg::OP_REALLOC, 1'b1, a, 13'd20);
    send_request(ffpa_pkg::OP_REALLOC, 1'b1, a, 13'd200);
    send_request(ffpa_pkg::OP_REALLOC, 1'b1, 12'd8, 13'd4096);
    // double free, free and reallocate off a block, unknown opcode, a large allocate
    send_request(ffpa_pkg::OP_FREE,    1'b1, 12'd8,    13'd0);
    send_request(ffpa_pkg::OP_FREE,    1'b1, 12'd8,    13'd0);
    send_request(ffpa_pkg::OP_FREE,    1'b1, 12'd13,   13'd0);
    send_request(ffpa_pkg::OP_REALLOC, 1'b1, 12'd2047, 13'd5);
    send_request(OP_UNKNOWN,           1'b1, 12'hFFF,  13'h1FFF);
    send_request(ffpa_pkg::OP_ALLOC,   1'b0, 12'd0,    13'd4000);
  endtask

  // Mostly well-formed sequences over live blocks, with some noise.
  task automatic test_random_traffic(int unsigned count);
    int unsigned roll;
    int unsigned burst_left;
    logic [11:0] addr;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(5, 40);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      addr = (live_blocks.size() != 0) ?
             live_blocks[$urandom_range(0, live_blocks.size() - 1)] : 12'd8;
      if (roll < 38 || (roll < 75 && live_blocks.size() == 0))
        send_request(ffpa_pkg::OP_ALLOC, 1'b0, 12'd0, draw_size());
      else if (roll < 62)
        send_request(ffpa_pkg::OP_FREE, 1'b1, addr, 13'($urandom()));
      else if (roll < 80)
        send_request(ffpa_pkg::OP_REALLOC, 1'b1, addr, draw_size());
      else if (roll < 84)
        send_request(ffpa_pkg::OP_REALLOC, 1'b0, 12'($urandom()), draw_size());
      else if (roll < 88)
        send_request(ffpa_pkg::OP_FREE, 1'b0, 12'($urandom()), 13'($urandom()));
      else if (roll < 92)
        send_request(OP_UNKNOWN, 1'($urandom()), 12'($urandom()), 13'($urandom()));
      else if (roll < 96)
        send_request(ffpa_pkg::OP_FREE, 1'b1, 12'($urandom()), 13'd0);
      else
        send_request(ffpa_pkg::OP_REALLOC, 1'b1, 12'($urandom()),
                     13'($urandom_range(0, 4096)));
      // now and then let every result come home before carrying on
      if ($urandom_range(0, 199) == 0) begin
        lower_start();
        drain_results();
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pool_sizes();
    write_pool_bytes(13'd16);
    test_random_traffic(60);
    write_pool_bytes(13'd17);
    test_random_traffic(40);
    write_pool_bytes(13'd100);
    test_random_traffic(200);
    write_pool_bytes(13'($urandom_range(16, 4096)));
    test_random_traffic(300);
    write_pool_bytes(13'h1FFF);
    test_random_traffic(300);
    write_pool_bytes(13'd4096);
    test_random_traffic(400);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    mismatches  = 0;
    no_idle     = 1'b0;
    pool_reg    = ffpa_pkg::RESET_POOL;
    empty_pool();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_random_traffic(600);
    test_pool_sizes();

    lower_start();
    drain_results();
    repeat (100) @(negedge clk_i);

    $display("Covered %0d allocates, %0d frees, %0d reallocates (%0d moved, %0d refused)",
             n_alloc, n_free, n_realloc, n_moved, n_refused);
    $display("over %0d pool sizes; %0d results checked, %0d mismatches",
             n_cfg + 1, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
